/* hw/rtl/elws_pkg.sv */
// ----------------------------------------------------------------------------
// elws_pkg
// Shared constants, codes and controller/datapath signal groups for the
// EEPROM log write sequencer.
// ----------------------------------------------------------------------------
package elws_pkg;

  // Queue and log geometry
  localparam int QUEUE_DEPTH  = 8;
  localparam int SLOT_COUNT   = 8;
  localparam int RECORD_BYTES = 8;

  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int OFF_W  = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

  localparam int REC_W  = 64;
  localparam int BYTE_W = 8;
  localparam int ADDR_W = 8;
  localparam int KIND_W = 2;

  // EEPROM map and gap pacing
  localparam logic [ADDR_W-1:0] LOG_START_ADDR = 8'h08;
  localparam logic [ADDR_W-1:0] LOG_INDEX_ADDR = 8'h01;
  localparam logic [BYTE_W-1:0] GAP_RESET      = 8'd5;
  localparam logic [BYTE_W-1:0] GAP_MAX        = 8'hFF;

  // Item actions
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DROPPED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE    = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_item;
    logic push;
    logic drop;
    logic pop;
    logic tick;
    logic write_data;
    logic write_index;
  } elws_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_tick;
    logic q_full;
    logic q_empty;
    logic gap_ok;
    logic last_byte;
    logic out_free;
  } elws_sts_t;

endpackage

/* hw/rtl/elws_if.sv */
// ----------------------------------------------------------------------------
// elws_if
// Valid/ready channel interfaces: log items in, results out, gap register
// writes.
// ----------------------------------------------------------------------------
interface elws_item_if;
  logic                           valid;
  logic                           ready;
  logic                           action;
  logic [elws_pkg::REC_W-1:0]     log_record;

  modport source (output valid, action, log_record, input ready);
  modport sink   (input valid, action, log_record, output ready);
endinterface

interface elws_result_if;
  logic                           valid;
  logic                           ready;
  logic [elws_pkg::KIND_W-1:0]    kind;
  logic [elws_pkg::ADDR_W-1:0]    write_address;
  logic [elws_pkg::BYTE_W-1:0]    write_byte;

  modport source (output valid, kind, write_address, write_byte, input ready);
  modport sink   (input valid, kind, write_address, write_byte, output ready);
endinterface

interface elws_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [elws_pkg::BYTE_W-1:0]    write_gap_ticks;

  modport source (output valid, write_gap_ticks, input ready);
  modport sink   (input valid, write_gap_ticks, output ready);
endinterface

/* hw/rtl/elws_ram.sv */
// ----------------------------------------------------------------------------
// elws_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module elws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/elws_dp.sv */
// ----------------------------------------------------------------------------
// elws_dp
// Datapath: item capture, record queue, writer registers, gap counter,
// gap register and the result register.
// ----------------------------------------------------------------------------
module elws_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item payload
  input  logic                          action_i,
  input  logic [elws_pkg::REC_W-1:0]    log_record_i,
  // gap register write
  input  logic                          cfg_we_i,
  input  logic [elws_pkg::BYTE_W-1:0]   cfg_data_i,
  // result channel
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [elws_pkg::KIND_W-1:0]   res_kind_o,
  output logic [elws_pkg::ADDR_W-1:0]   res_addr_o,
  output logic [elws_pkg::BYTE_W-1:0]   res_byte_o,
  // controller
  input  elws_pkg::elws_cmd_t           cmd_i,
  output elws_pkg::elws_sts_t           sts_o
);

  localparam logic [elws_pkg::QPTR_W-1:0] QLAST =
    elws_pkg::QPTR_W'(elws_pkg::QUEUE_DEPTH - 1);
  localparam logic [elws_pkg::SLOT_W-1:0] SLAST =
    elws_pkg::SLOT_W'(elws_pkg::SLOT_COUNT - 1);
  localparam logic [elws_pkg::OFF_W-1:0]  OLAST =
    elws_pkg::OFF_W'(elws_pkg::RECORD_BYTES - 1);
  localparam logic [elws_pkg::ADDR_W-1:0] REC_BYTES_A =
    elws_pkg::ADDR_W'(elws_pkg::RECORD_BYTES);

  // Captured item
  logic                          action_q;
  logic [elws_pkg::REC_W-1:0]    record_q;

  // Queue pointers
  logic [elws_pkg::QPTR_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [elws_pkg::QPTR_W-1:0]   head_inc, tail_inc;
  logic [elws_pkg::REC_W-1:0]    ram_rdata;

  // Writer registers
  logic [elws_pkg::REC_W-1:0]    held_q;
  logic [elws_pkg::OFF_W-1:0]    off_q, off_d;
  logic [elws_pkg::SLOT_W-1:0]   slot_q, slot_d, slot_inc;
  logic [elws_pkg::BYTE_W-1:0]   gap_q, gap_d, gap_inc;
  logic [elws_pkg::BYTE_W-1:0]   gap_ticks_q;

  // Result register
  logic                          res_valid_q, res_valid_d;
  logic [elws_pkg::KIND_W-1:0]   res_kind_q;
  logic [elws_pkg::ADDR_W-1:0]   res_addr_q;
  logic [elws_pkg::BYTE_W-1:0]   res_byte_q;
  logic [elws_pkg::ADDR_W-1:0]   data_addr;
  logic                          emit;

  // Pointer arithmetic
  assign head_inc = (head_q == QLAST) ? '0 : head_q + 1'b1;
  assign tail_inc = (tail_q == QLAST) ? '0 : tail_q + 1'b1;
  assign slot_inc = (slot_q == SLAST) ? '0 : slot_q + 1'b1;
  assign gap_inc  = (gap_q == elws_pkg::GAP_MAX) ? gap_q : gap_q + 1'b1;

  // Status to the controller
  assign sts_o.is_tick   = (action_q == elws_pkg::ACT_TICK);
  assign sts_o.q_full    = (head_inc == tail_q);
  assign sts_o.q_empty   = (head_q == tail_q);
  assign sts_o.gap_ok    = (gap_inc >= gap_ticks_q);
  assign sts_o.last_byte = (off_q == OLAST);
  assign sts_o.out_free  = !res_valid_q || res_ready_i;

  // Record queue storage; read port follows the tail
  elws_ram #(
    .WIDTH (elws_pkg::REC_W),
    .DEPTH (elws_pkg::QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (head_q),
    .wdata_i (record_q),
    .raddr_i (tail_q),
    .rdata_o (ram_rdata)
  );

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      action_q <= action_i;
      record_q <= log_record_i;
    end
  end

  // Next-state for pointers, offset, slot and gap
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    off_d  = off_q;
    slot_d = slot_q;
    gap_d  = gap_q;
    if (cmd_i.push) begin
      head_d = head_inc;
    end
    if (cmd_i.pop) begin
      tail_d = tail_inc;
      off_d  = '0;
    end
    if (cmd_i.tick) begin
      gap_d = gap_inc;
    end
    if (cmd_i.write_data) begin
      off_d = off_q + 1'b1;
      gap_d = '0;
    end
    if (cmd_i.write_index) begin
      slot_d = slot_inc;
      gap_d  = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      off_q       <= '0;
      slot_q      <= '0;
      gap_q       <= '0;
      gap_ticks_q <= elws_pkg::GAP_RESET;
      held_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      off_q       <= off_d;
      slot_q      <= slot_d;
      gap_q       <= gap_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        gap_ticks_q <= cfg_data_i;
      end
      if (cmd_i.pop) begin
        held_q <= ram_rdata;
      end
    end
  end

  // Log byte address: start + slot * record size + offset
  assign data_addr = elws_pkg::LOG_START_ADDR
                   + elws_pkg::ADDR_W'(slot_q) * REC_BYTES_A
                   + elws_pkg::ADDR_W'(off_q);

  assign emit = cmd_i.push || cmd_i.drop || cmd_i.write_data || cmd_i.write_index;

  // Result valid: a new result wins over the one being taken
  always_comb begin
    res_valid_d = res_valid_q;
    if (res_valid_q && res_ready_i) begin
      res_valid_d = 1'b0;
    end
    if (emit) begin
      res_valid_d = 1'b1;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      res_kind_q <= elws_pkg::KIND_ACCEPTED;
      res_addr_q <= '0;
      res_byte_q <= '0;
    end else if (cmd_i.drop) begin
      res_kind_q <= elws_pkg::KIND_DROPPED;
      res_addr_q <= '0;
      res_byte_q <= '0;
    end else if (cmd_i.write_data) begin
      res_kind_q <= elws_pkg::KIND_WRITE;
      res_addr_q <= data_addr;
      res_byte_q <= held_q[elws_pkg::BYTE_W*off_q +: elws_pkg::BYTE_W];
    end else if (cmd_i.write_index) begin
      res_kind_q <= elws_pkg::KIND_WRITE;
      res_addr_q <= elws_pkg::LOG_INDEX_ADDR;
      res_byte_q <= elws_pkg::BYTE_W'(slot_inc);
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_kind_o  = res_kind_q;
  assign res_addr_o  = res_addr_q;
  assign res_byte_o  = res_byte_q;

endmodule

/* hw/rtl/elws_ctrl.sv */
// ----------------------------------------------------------------------------
// elws_ctrl
// Controller: item handshake sequencing and the four-phase writer state
// machine (idle, data, index, settle).
// ----------------------------------------------------------------------------
module elws_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  output logic                 item_ready_o,
  input  elws_pkg::elws_sts_t  sts_i,
  output elws_pkg::elws_cmd_t  cmd_o
);

  // Item sequencing states
  localparam logic ST_READY = 1'b0;
  localparam logic ST_EXEC  = 1'b1;

  // Writer phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_INDEX  = 2'd2;
  localparam logic [1:0] PH_SETTLE = 2'd3;

  logic       st_q, st_d;
  logic [1:0] ph_q, ph_d;

  assign item_ready_o = (st_q == ST_READY);

  // Next state and commands
  always_comb begin
    st_d  = st_q;
    ph_d  = ph_q;
    cmd_o = '0;
    case (st_q)
      ST_READY: begin
        if (item_valid_i) begin
          cmd_o.load_item = 1'b1;
          st_d            = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // hold until the result register can take a new transaction
        if (sts_i.out_free) begin
          st_d = ST_READY;
          if (!sts_i.is_tick) begin
            cmd_o.push = !sts_i.q_full;
            cmd_o.drop = sts_i.q_full;
          end else begin
            cmd_o.tick = 1'b1;
            case (ph_q)
              PH_IDLE: begin
                if (!sts_i.q_empty) begin
                  cmd_o.pop = 1'b1;
                  ph_d      = PH_DATA;
                end
              end
              PH_DATA: begin
                if (sts_i.gap_ok) begin
                  cmd_o.write_data = 1'b1;
                  if (sts_i.last_byte) begin
                    ph_d = PH_INDEX;
                  end
                end
              end
              PH_INDEX: begin
                if (sts_i.gap_ok) begin
                  cmd_o.write_index = 1'b1;
                  ph_d              = PH_SETTLE;
                end
              end
              default: begin
                if (sts_i.gap_ok) begin
                  ph_d = PH_IDLE;
                end
              end
            endcase
          end
        end
      end
      default: begin
        st_d = ST_READY;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_READY;
      ph_q <= PH_IDLE;
    end else begin
      st_q <= st_d;
      ph_q <= ph_d;
    end
  end

endmodule

/* hw/rtl/eeprom_log_write_sequencer.sv */
// ----------------------------------------------------------------------------
// eeprom_log_write_sequencer
// Ring-queued log records written out to EEPROM one byte per permitted tick,
// followed by the slot index update.
// ----------------------------------------------------------------------------
//  channel   | direction | payload                                | handshake
//  item_i    | in        | action, log_record                     | valid/ready
//  result_o  | out       | kind, write_address, write_byte        | valid/ready
//  cfg_i     | in        | write_gap_ticks                        | valid/ready
//
//  An item is taken in first and then executed against the queue and
//  writer state; execution holds while the result register still carries
//  an untaken transaction.
//  The queue RAM read port follows the tail pointer, so a pop captures the
//  tail entry from the registered read data. cfg_i is always ready.
//  Reset clears pointers, writer phase, slot index and gap counter at once;
//  there is no clearing pass over the queue RAM.
// ----------------------------------------------------------------------------
module eeprom_log_write_sequencer (
  input  logic          clk_i,
  input  logic          rst_ni,
  elws_item_if.sink     item_i,
  elws_result_if.source result_o,
  elws_cfg_if.sink      cfg_i
);

  elws_pkg::elws_cmd_t cmd;
  elws_pkg::elws_sts_t sts;
  logic                item_ready;

  assign item_i.ready = item_ready;
  assign cfg_i.ready  = 1'b1;

  // Controller
  elws_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_i.valid),
    .item_ready_o (item_ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  // Datapath
  elws_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .action_i     (item_i.action),
    .log_record_i (item_i.log_record),
    .cfg_we_i     (cfg_i.valid),
    .cfg_data_i   (cfg_i.write_gap_ticks),
    .res_valid_o  (result_o.valid),
    .res_ready_i  (result_o.ready),
    .res_kind_o   (result_o.kind),
    .res_addr_o   (result_o.write_address),
    .res_byte_o   (result_o.write_byte),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule
